/* rtl/tsfc_pkg.sv */
// Shared types and constants for the touch sample filter chain.
package tsfc_pkg;

  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;
  localparam int LIM2_W    = 2 * CFG_W;

  localparam logic [CFG_IDX_W-1:0] REG_OUTLIER_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESTART_LIMIT = 1'd1;

  localparam logic [LIM2_W-1:0] LIM2_RESET = LIM2_W'(100);

  localparam logic [2:0] HIST_DEPTH = 3'd4;
  localparam logic [2:0] CNT_ONE    = 3'd1;
  localparam logic [2:0] CNT_TWO    = 3'd2;
  localparam logic [2:0] CNT_THREE  = 3'd3;

  // rows: 2, 3 and 4 points; weights newest first, last column is the shift
  localparam logic [3:0] WTAB [3][5] = '{
    '{4'd5, 4'd3, 4'd0, 4'd0, 4'd3},
    '{4'd8, 4'd5, 4'd3, 4'd0, 4'd4},
    '{4'd6, 4'd4, 4'd3, 4'd3, 4'd4}
  };

  typedef struct packed {
    logic       en1;
    logic       take_good;
    logic       take_susp;
    logic       en2_pt;
    logic       seed;
    logic       en3_pt;
    logic       en4;
    logic       rel4;
    logic [2:0] cnt4;
  } tsfc_ctrl_t;

endpackage

/* rtl/tsfc_lane.sv */
// One coordinate axis: outlier, smoother, history and weighted average datapath.
module tsfc_lane #(
  parameter int CW = 12
) (
  input  logic                    clk_i,
  input  tsfc_pkg::tsfc_ctrl_t    ctrl_i,
  input  logic [CW-1:0]           in_coord_i,
  output logic [2*CW-1:0]         sq_good_o,
  output logic [2*CW-1:0]         sq_susp_o,
  output logic [2*CW-1:0]         sq_hist_o,
  output logic [CW-1:0]           out_coord_o
);
  import tsfc_pkg::*;

  localparam int WS_W = CW + 4;

  logic [CW-1:0]   good_q, susp_q, s1_q, smooth_q, out_q;
  logic [CW-1:0]   hist_q [3];
  logic [CW-1:0]   pts_q  [4];
  logic [CW-1:0]   dg, ds, dh, smooth_d, avg;
  logic [CW+2:0]   acc;
  logic [WS_W-1:0] sum [3];

  always_comb begin
    dg = (in_coord_i > good_q) ? in_coord_i - good_q : good_q - in_coord_i;
    ds = (in_coord_i > susp_q) ? in_coord_i - susp_q : susp_q - in_coord_i;
    dh = (smooth_q > hist_q[0]) ? smooth_q - hist_q[0] : hist_q[0] - smooth_q;
  end

  assign sq_good_o = (2*CW)'(dg) * (2*CW)'(dg);
  assign sq_susp_o = (2*CW)'(ds) * (2*CW)'(ds);
  assign sq_hist_o = (2*CW)'(dh) * (2*CW)'(dh);

  // smooth = (old*5 + new*3) >> 3
  always_comb begin
    acc = ({3'b0, smooth_q} << 2) + {3'b0, smooth_q} + ({3'b0, s1_q} << 1) + {3'b0, s1_q};
    smooth_d = ctrl_i.seed ? s1_q : acc[CW+2:3];
  end

  // taps with zero weight are skipped so entries outside the count never reach the sum
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = '0;
      for (int i = 0; i < 4; i++) begin
        if (WTAB[r][i] != 4'd0) begin
          sum[r] = sum[r] + WS_W'(pts_q[i]) * WS_W'(WTAB[r][i]);
        end
      end
    end
    case (ctrl_i.cnt4)
      CNT_ONE:   avg = pts_q[0];
      CNT_TWO:   avg = CW'(sum[0] >> WTAB[0][4]);
      CNT_THREE: avg = CW'(sum[1] >> WTAB[1][4]);
      default:   avg = CW'(sum[2] >> WTAB[2][4]);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en1) begin
      s1_q <= in_coord_i;
    end
    if (ctrl_i.take_good) begin
      good_q <= in_coord_i;
    end
    if (ctrl_i.take_susp) begin
      susp_q <= in_coord_i;
    end
    if (ctrl_i.en2_pt) begin
      smooth_q <= smooth_d;
    end
    if (ctrl_i.en3_pt) begin
      hist_q[0] <= smooth_q;
      hist_q[1] <= hist_q[0];
      hist_q[2] <= hist_q[1];
      pts_q[0]  <= smooth_q;
      pts_q[1]  <= hist_q[0];
      pts_q[2]  <= hist_q[1];
      pts_q[3]  <= hist_q[2];
    end
    if (ctrl_i.en4) begin
      out_q <= ctrl_i.rel4 ? '0 : avg;
    end
  end

  assign out_coord_o = out_q;

endmodule

/* rtl/touch_sample_filter_chain_unit.sv */
// Top level of the touch sample filter chain: control, lane merge and stream ports.
// Throughput: one transaction per cycle while the output is not stalled; four register
// stages (outlier, smoother, dejitter history, weighted average) each hold one item
// and advance independently.
// Reset: asynchronous, clears control and valid state but not the lane data registers; both limits return to 10.
module touch_sample_filter_chain_unit #(
  parameter int COORD_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]   s_axis_tdata,  // sample_x, sample_y
  input  logic                                s_axis_tuser,  // command
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [((2*COORD_BITS+7)/8)*8-1:0]   m_axis_tdata,  // point_x, point_y
  output logic                                m_axis_tuser,  // kind
  input  logic                                cfg_we_i,
  input  logic [tsfc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tsfc_pkg::CFG_W-1:0]          cfg_data_i
);
  import tsfc_pkg::*;

  localparam int CW     = COORD_BITS;
  localparam int TD_W   = ((2*CW+7)/8)*8;
  localparam int SQ_W   = 2*CW + 1;
  localparam int CMP_W  = (SQ_W > LIM2_W) ? SQ_W : LIM2_W;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_TRACK   = 2'd1,
    MODE_SUSPECT = 2'd2
  } mode_e;

  tsfc_ctrl_t      ctrl;
  logic [2*CW-1:0] sq_good [2];
  logic [2*CW-1:0] sq_susp [2];
  logic [2*CW-1:0] sq_hist [2];
  logic [CW-1:0]   lane_out [2];

  logic [LIM2_W-1:0] out_lim2_q, rst_lim2_q;
  mode_e             mode_q, mode_d;
  logic              v1_q, cmd1_q, pass1_q, pass_d;
  logic              v2_q, cmd2_q, seeded_q;
  logic              v3_q, kind3_q, emitted_q;
  logic [2:0]        cnt_q, cnt3_q, cnt_new;
  logic              m_valid_q, m_kind_q;
  logic              rdy1, rdy2, rdy3, rdy4, en1, en2, en3, en4;
  logic              near_good, near_susp, restart;
  logic              take_good, take_susp;
  logic [CMP_W-1:0]  d_good, d_susp, d_hist;

  for (genvar g = 0; g < 2; g++) begin : g_lane
    tsfc_lane #(.CW(CW)) u_lane (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .in_coord_i  (s_axis_tdata[g*CW +: CW]),
      .sq_good_o   (sq_good[g]),
      .sq_susp_o   (sq_susp[g]),
      .sq_hist_o   (sq_hist[g]),
      .out_coord_o (lane_out[g])
    );
  end

  // handshake chain
  assign rdy4 = !m_valid_q || m_axis_tready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign en1  = s_axis_tvalid && rdy1;
  assign en2  = v1_q && rdy2;
  assign en3  = v2_q && rdy3;
  assign en4  = v3_q && rdy4;

  // merge lane distances
  always_comb begin
    d_good    = CMP_W'(sq_good[0]) + CMP_W'(sq_good[1]);
    d_susp    = CMP_W'(sq_susp[0]) + CMP_W'(sq_susp[1]);
    d_hist    = CMP_W'(sq_hist[0]) + CMP_W'(sq_hist[1]);
    near_good = d_good < CMP_W'(out_lim2_q);
    near_susp = d_susp < CMP_W'(out_lim2_q);
    restart   = (cnt_q != 3'd0) && (d_hist > CMP_W'(rst_lim2_q));
    if (restart) begin
      cnt_new = CNT_ONE;
    end else if (cnt_q == HIST_DEPTH) begin
      cnt_new = HIST_DEPTH;
    end else begin
      cnt_new = cnt_q + 3'd1;
    end
  end

  // outlier stage
  always_comb begin
    mode_d    = mode_q;
    pass_d    = 1'b0;
    take_good = 1'b0;
    take_susp = 1'b0;
    if (s_axis_tuser) begin
      mode_d = MODE_IDLE;
    end else begin
      case (mode_q)
        MODE_TRACK: begin
          if (near_good) begin
            pass_d    = 1'b1;
            take_good = en1;
          end else begin
            take_susp = en1;
            mode_d    = MODE_SUSPECT;
          end
        end
        MODE_SUSPECT: begin
          pass_d    = near_susp || near_good;
          take_good = en1;
          mode_d    = MODE_TRACK;
        end
        default: begin
          take_good = en1;
          mode_d    = MODE_TRACK;
        end
      endcase
    end
  end

  always_comb begin
    ctrl.en1       = en1;
    ctrl.take_good = take_good;
    ctrl.take_susp = take_susp;
    ctrl.en2_pt    = en2 && !cmd1_q && pass1_q;
    ctrl.seed      = !seeded_q;
    ctrl.en3_pt    = en3 && !cmd2_q;
    ctrl.en4       = en4;
    ctrl.rel4      = kind3_q;
    ctrl.cnt4      = cnt3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_lim2_q <= LIM2_RESET;
      rst_lim2_q <= LIM2_RESET;
      mode_q     <= MODE_IDLE;
      v1_q       <= 1'b0;
      cmd1_q     <= 1'b0;
      pass1_q    <= 1'b0;
      v2_q       <= 1'b0;
      cmd2_q     <= 1'b0;
      seeded_q   <= 1'b0;
      v3_q       <= 1'b0;
      kind3_q    <= 1'b0;
      emitted_q  <= 1'b0;
      cnt_q      <= 3'd0;
      cnt3_q     <= 3'd0;
      m_valid_q  <= 1'b0;
      m_kind_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_OUTLIER_LIMIT: out_lim2_q <= LIM2_W'(cfg_data_i) * LIM2_W'(cfg_data_i);
          REG_RESTART_LIMIT: rst_lim2_q <= LIM2_W'(cfg_data_i) * LIM2_W'(cfg_data_i);
          default: ;
        endcase
      end
      // stage 1
      if (rdy1) begin
        v1_q <= en1;
      end
      if (en1) begin
        mode_q  <= mode_d;
        cmd1_q  <= s_axis_tuser;
        pass1_q <= pass_d;
      end
      // stage 2
      if (rdy2) begin
        v2_q <= en2 && (cmd1_q || (pass1_q && seeded_q));
      end
      if (en2) begin
        cmd2_q <= cmd1_q;
        if (cmd1_q) begin
          seeded_q <= 1'b0;
        end else if (pass1_q) begin
          seeded_q <= 1'b1;
        end
      end
      // stage 3
      if (rdy3) begin
        v3_q <= en3 && (!cmd2_q || emitted_q);
      end
      if (en3) begin
        kind3_q <= cmd2_q;
        if (cmd2_q) begin
          cnt_q     <= 3'd0;
          emitted_q <= 1'b0;
        end else begin
          cnt_q     <= cnt_new;
          cnt3_q    <= cnt_new;
          emitted_q <= 1'b1;
        end
      end
      // stage 4
      if (rdy4) begin
        m_valid_q <= en4;
      end
      if (en4) begin
        m_kind_q <= kind3_q;
      end
    end
  end

  assign s_axis_tready = rdy1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tdata  = TD_W'({lane_out[1], lane_out[0]});

  a_release_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("release transaction carries nonzero point");

  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !kind3_q |-> (cnt3_q != 3'd0 && cnt3_q <= HIST_DEPTH))
    else $error("history count out of range for point");

  a_release_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    en3 && cmd2_q |=> !emitted_q && cnt_q == 3'd0)
    else $error("release did not clear dejitter state");

  a_hist_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= HIST_DEPTH)
    else $error("history count exceeds depth");

endmodule

/* verif/touch_sample_filter_chain_unit_test.sv */
`timescale 1ns / 1ps
// Self-checking stream testbench for the touch sample filter chain: predicts each filtered point.
module touch_sample_filter_chain_unit_test;
  import tsfc_pkg::*;

  localparam int COORD_W      = 12;
  localparam int COORD_MAX    = (1 << COORD_W) - 1;
  localparam int DATA_W       = ((2 * COORD_W + 7) / 8) * 8;
  localparam int ITEM_TARGET  = 1950;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_WAIT     = 16;
  localparam int LIMIT_RESET  = 10;

  localparam bit CMD_SAMPLE   = 1'b0;
  localparam bit CMD_RELEASE  = 1'b1;
  localparam bit KIND_POINT   = 1'b0;
  localparam bit KIND_RELEASE = 1'b1;

  localparam logic [1:0] MODE_EMPTY   = 2'd0;
  localparam logic [1:0] MODE_TRACK   = 2'd1;
  localparam logic [1:0] MODE_SUSPECT = 2'd2;

  localparam int IIR_OLD_W = 5;
  localparam int IIR_NEW_W = 3;
  localparam int IIR_SHIFT = 3;
  localparam int HIST_LEN  = 4;

  // rows for 2, 3, 4 stored points; taps newest first, last column is the shift
  localparam int AVG_WEIGHT [3][5] = '{
    '{5, 3, 0, 0, 3},
    '{8, 5, 3, 0, 4},
    '{6, 4, 3, 3, 4}
  };

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct {
    bit     kind;
    coord_t px;
    coord_t py;
  } result_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [DATA_W-1:0]    s_axis_tdata  = '0;
  logic                 s_axis_tuser  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [DATA_W-1:0]    m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [CFG_W-1:0]     cfg_data_i    = '0;

  // predictor state
  logic [1:0] flt_mode;
  coord_t     good_x, good_y, susp_x, susp_y;
  bit         iir_seeded;
  coord_t     iir_x, iir_y;
  coord_t     hist_x [HIST_LEN];
  coord_t     hist_y [HIST_LEN];
  logic [1:0] hist_head;
  int         hist_cnt;
  bit         point_emitted;
  int         lim_near, lim_restart;

  result_t pending_points [$];
  int      mismatch_cnt = 0;
  int      items_sent   = 0;
  int      cycle_cnt    = 0;
  int      rx_hold      = 0;
  bit      no_gaps      = 1'b0;

  touch_sample_filter_chain_unit #(
    .COORD_BITS(COORD_W)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("** touch_sample_filter_chain_unit: FAILED **");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    mismatch_cnt++;
    $display("%0t: %s", $time, what);
  endtask

  function automatic longint dist_sq(coord_t ax, coord_t ay, coord_t bx, coord_t by);
    longint dx, dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    return dx * dx + dy * dy;
  endfunction

  function automatic bit is_close(coord_t ax, coord_t ay, coord_t bx, coord_t by);
    return dist_sq(ax, ay, bx, by) < longint'(lim_near) * lim_near;
  endfunction

  task automatic dejitter_point(input coord_t x, input coord_t y,
                                output coord_t ox, output coord_t oy);
    logic [1:0] prev, k;
    int         sx, sy, row;
    point_emitted = 1'b1;
    if (hist_cnt != 0) begin
      prev = hist_head - 2'd1;
      if (dist_sq(x, y, hist_x[prev], hist_y[prev]) > longint'(lim_restart) * lim_restart)
        hist_cnt = 0;
    end
    hist_x[hist_head] = x;
    hist_y[hist_head] = y;
    if (hist_cnt < HIST_LEN) hist_cnt++;
    ox = x;
    oy = y;
    if (hist_cnt > 1) begin
      row = hist_cnt - 2;
      k   = hist_head;
      sx  = 0;
      sy  = 0;
      for (int i = 0; i < hist_cnt; i++) begin
        sx += int'(hist_x[k]) * AVG_WEIGHT[row][i];
        sy += int'(hist_y[k]) * AVG_WEIGHT[row][i];
        k = k - 2'd1;
      end
      ox = coord_t'(sx >> AVG_WEIGHT[row][4]);
      oy = coord_t'(sy >> AVG_WEIGHT[row][4]);
    end
    hist_head = hist_head + 2'd1;
  endtask

  task automatic filter_chain_predict(input bit cmd, input coord_t x, input coord_t y);
    bit      pass;
    result_t res;
    pass = 1'b0;
    if (cmd == CMD_RELEASE) begin
      flt_mode   = MODE_EMPTY;
      iir_seeded = 1'b0;
      hist_head  = '0;
      hist_cnt   = 0;
      if (point_emitted) begin
        point_emitted = 1'b0;
        res.kind = KIND_RELEASE;
        res.px   = '0;
        res.py   = '0;
        pending_points.push_back(res);
      end
      return;
    end
    case (flt_mode)
      MODE_TRACK: begin
        if (is_close(x, y, good_x, good_y)) begin
          good_x = x;
          good_y = y;
          pass   = 1'b1;
        end else begin
          susp_x   = x;
          susp_y   = y;
          flt_mode = MODE_SUSPECT;
        end
      end
      MODE_SUSPECT: begin
        pass     = is_close(x, y, susp_x, susp_y) || is_close(x, y, good_x, good_y);
        good_x   = x;
        good_y   = y;
        flt_mode = MODE_TRACK;
      end
      default: begin
        good_x   = x;
        good_y   = y;
        flt_mode = MODE_TRACK;
      end
    endcase
    if (!pass) return;
    if (!iir_seeded) begin
      iir_x      = x;
      iir_y      = y;
      iir_seeded = 1'b1;
      return;
    end
    iir_x = coord_t'((int'(iir_x) * IIR_OLD_W + int'(x) * IIR_NEW_W) >> IIR_SHIFT);
    iir_y = coord_t'((int'(iir_y) * IIR_OLD_W + int'(y) * IIR_NEW_W) >> IIR_SHIFT);
    dejitter_point(iir_x, iir_y, res.px, res.py);
    res.kind = KIND_POINT;
    pending_points.push_back(res);
  endtask

  task automatic send_item(input bit cmd, input coord_t x, input coord_t y);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= DATA_W'({y, x});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    filter_chain_predict(cmd, x, y);
    items_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_OUTLIER_LIMIT) lim_near = value;
    else lim_restart = value;
  endtask

  task automatic set_limits(input int near_lim, input int restart_lim);
    wait_idle();
    write_reg(REG_OUTLIER_LIMIT, near_lim);
    write_reg(REG_RESTART_LIMIT, restart_lim);
  endtask

  function automatic coord_t rand_coord();
    return coord_t'($urandom_range(0, COORD_MAX));
  endfunction

  function automatic coord_t nudge(coord_t c, int span);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return coord_t'(v);
  endfunction

  function automatic int pick_limit();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return COORD_MAX;
      2: return 1;
      3: return LIMIT_RESET;
      default: return $urandom_range(2, 64);
    endcase
  endfunction

  task automatic short_stroke(input int len);
    for (int i = 0; i < len; i++) send_item(CMD_SAMPLE, rand_coord(), rand_coord());
    send_item(CMD_RELEASE, rand_coord(), rand_coord());
  endtask

  task automatic test_directed();
    send_item(CMD_RELEASE, 12'hFFF, 12'hFFF);   // nothing emitted yet
    send_item(CMD_SAMPLE, 12'd0, 12'd0);        // first point only stored
    send_item(CMD_SAMPLE, 12'd0, 12'd0);        // seeds smoother
    send_item(CMD_SAMPLE, 12'd3, 12'd4);
    send_item(CMD_SAMPLE, 12'd4095, 12'd4095);  // suspect
    send_item(CMD_SAMPLE, 12'd4095, 12'd4090);  // near suspect, passes
    send_item(CMD_SAMPLE, 12'd5, 12'd5);        // suspect
    send_item(CMD_SAMPLE, 12'd4000, 12'd4000);  // near neither, dropped
    send_item(CMD_SAMPLE, 12'd4001, 12'd4000);
    send_item(CMD_SAMPLE, 12'd4002, 12'd4001);
    send_item(CMD_SAMPLE, 12'd4003, 12'd4003);
    send_item(CMD_SAMPLE, 12'd4004, 12'd4004);
    send_item(CMD_RELEASE, 12'hABC, 12'h543);
    send_item(CMD_RELEASE, 12'h000, 12'h000);   // second release is silent
    send_item(CMD_SAMPLE, 12'd4095, 12'd0);
    send_item(CMD_SAMPLE, 12'd4095, 12'd0);
    send_item(CMD_SAMPLE, 12'd4095, 12'd9);
    send_item(CMD_SAMPLE, 12'd4095, 12'd19);    // distance exactly at limit
    send_item(CMD_SAMPLE, 12'd4095, 12'd29);
    send_item(CMD_RELEASE, 12'h555, 12'hAAA);
  endtask

  task automatic test_limit_extremes();
    set_limits(COORD_MAX, 0);
    short_stroke(6);
    set_limits(0, COORD_MAX);
    short_stroke(5);
    set_limits(COORD_MAX, COORD_MAX);
    short_stroke(6);
  endtask

  task automatic test_random_strokes();
    coord_t cx, cy;
    int     len, span, pick, strokes;
    strokes = 0;
    while (items_sent < ITEM_TARGET) begin
      if (strokes % 12 == 0) begin
        set_limits(pick_limit(), pick_limit());
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      cx   = rand_coord();
      cy   = rand_coord();
      len  = $urandom_range(1, 30);
      span = ($urandom_range(0, 3) == 0) ? 3 * lim_near + 4 : lim_near / 2 + 2;
      for (int i = 0; i < len; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          send_item(CMD_SAMPLE, rand_coord(), rand_coord());   // lone outlier
        end else if (pick < 8) begin
          cx = rand_coord();
          cy = rand_coord();
          send_item(CMD_SAMPLE, cx, cy);
        end else if (pick < 10) begin
          send_item(CMD_RELEASE, rand_coord(), rand_coord());
        end else begin
          cx = nudge(cx, span);
          cy = nudge(cy, span);
          send_item(CMD_SAMPLE, cx, cy);
        end
      end
      send_item(CMD_RELEASE, rand_coord(), rand_coord());
      if ($urandom_range(0, 7) == 0) send_item(CMD_RELEASE, rand_coord(), rand_coord());
      strokes++;
      if (strokes == 3) wait_idle();
    end
  endtask

  // result checker and receiver stalls
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_points.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction kind=%0d data=%h",
                                  m_axis_tuser, m_axis_tdata));
      end else begin
        want = pending_points.pop_front();
        if (m_axis_tuser !== want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", m_axis_tuser, want.kind));
        if (m_axis_tdata[COORD_W-1:0] !== want.px)
          report_mismatch($sformatf("point_x %0d, want %0d",
                                    m_axis_tdata[COORD_W-1:0], want.px));
        if (m_axis_tdata[2*COORD_W-1:COORD_W] !== want.py)
          report_mismatch($sformatf("point_y %0d, want %0d",
                                    m_axis_tdata[2*COORD_W-1:COORD_W], want.py));
      end
      rx_hold = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
    end else if (rx_hold > 0) begin
      rx_hold--;
    end
    m_axis_tready <= (rx_hold == 0);
  end

  initial begin
    flt_mode      = MODE_EMPTY;
    iir_seeded    = 1'b0;
    hist_head     = '0;
    hist_cnt      = 0;
    point_emitted = 1'b0;
    lim_near      = LIMIT_RESET;
    lim_restart   = LIMIT_RESET;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_limit_extremes();
    test_random_strokes();
    wait_idle();
    if (mismatch_cnt == 0) begin
      $display("** touch_sample_filter_chain_unit: PASSED **");
    end else begin
      $display("** touch_sample_filter_chain_unit: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/tsfc_pkg.sv
rtl/tsfc_lane.sv
rtl/touch_sample_filter_chain_unit.sv
verif/touch_sample_filter_chain_unit_test.sv
